[rtl/mcsq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mcsq_pkg;

  // Sizing
  localparam int NUM_LISTS   = 16;
  localparam int DEPTH       = 64;
  localparam int STORE_DEPTH = NUM_LISTS * DEPTH;

  localparam int LIST_ID_W = 4;
  localparam int VALUE_W   = 64;
  localparam int LIST_W    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int POS_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int SUM_W     = POS_W + 1;
  localparam int ADDR_W    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  // Command codes
  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_PUSH   = 2'd1,
    OP_POP    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_LIST = 3'd1,
    ST_EXISTS  = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_READ = 2'd2
  } state_t;

  typedef struct packed {
    logic [1:0]               operation;
    logic [LIST_ID_W-1:0]     list_id;
    logic                     kind;
    logic signed [VALUE_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic [2:0]                status;
    logic                      pop_valid;
    logic signed [VALUE_W-1:0] popped_value;
  } result_t;

endpackage

`default_nettype wire

[rtl/mcsq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Single-port RAM, registered read
module mcsq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic                           re,
  input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
  input  wire logic [WIDTH-1:0]               wdata,
  output logic      [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[rtl/multi_context_stack_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

// Multi-context stack / queue manager.
// Up to NUM_LISTS lists of 64-bit values share one value store; each list
// is created as a stack (push and pop at the head) or a queue (push at the
// tail, pop at the head) and owns a ring of DEPTH store entries.
// Command channel: a command transfer happens on a rising edge with start
// high and busy low. busy rises on the next cycle and stays high until the
// command has finished.
// Result channel: done is high for exactly one cycle with the result on
// result; the receiver cannot stall, so the result must be taken then.
// done follows the EXEC state for create, push, failed pops and unused codes;
// a successful pop passes through the extra READ state, which covers the
// registered read of the single-port value store.
// A new command is not taken while busy is high; one may be transferred in
// the cycle in which done is shown.
// Reset (rst, synchronous): all lists are marked absent, the sequencer
// returns to idle and no result is pending. The store itself is not cleared.
module multi_context_stack_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire mcsq_pkg::cmd_t    command,
  output logic                   done,
  output mcsq_pkg::result_t      result
);

  // List descriptors
  logic                         list_exists   [mcsq_pkg::NUM_LISTS];
  logic                         list_is_queue [mcsq_pkg::NUM_LISTS];
  logic [mcsq_pkg::POS_W-1:0]   head_index    [mcsq_pkg::NUM_LISTS];
  logic [mcsq_pkg::CNT_W-1:0]   entry_count   [mcsq_pkg::NUM_LISTS];

  mcsq_pkg::state_t  state, state_next;
  mcsq_pkg::cmd_t    cmd_q;
  mcsq_pkg::result_t result_next;
  logic              done_next;

  // Decoded command
  logic                         in_range;
  logic [mcsq_pkg::LIST_W-1:0]  lst;
  logic                         cur_exists;
  logic                         cur_queue;
  logic [mcsq_pkg::POS_W-1:0]   cur_head;
  logic [mcsq_pkg::CNT_W-1:0]   cur_count;
  logic [mcsq_pkg::SUM_W-1:0]   tail_sum;
  logic [mcsq_pkg::POS_W-1:0]   tail_pos;
  logic [mcsq_pkg::POS_W-1:0]   head_dec;
  logic [mcsq_pkg::POS_W-1:0]   head_inc;

  mcsq_pkg::status_t            ex_status;
  logic                         do_create;
  logic                         do_push;
  logic                         do_pop;
  logic [mcsq_pkg::POS_W-1:0]   slot_pos;
  logic [mcsq_pkg::POS_W-1:0]   new_head;
  logic [mcsq_pkg::ADDR_W-1:0]  ram_addr;
  logic                         ram_we;
  logic                         ram_re;
  logic [mcsq_pkg::VALUE_W-1:0] ram_rdata;

  assign in_range   = (32'(cmd_q.list_id) < mcsq_pkg::NUM_LISTS);
  assign lst        = mcsq_pkg::LIST_W'(cmd_q.list_id);
  assign cur_exists = in_range && list_exists[lst];
  assign cur_queue  = list_is_queue[lst];
  assign cur_head   = head_index[lst];
  assign cur_count  = entry_count[lst];

  // Ring arithmetic, modulo DEPTH by compare and subtract
  assign tail_sum = mcsq_pkg::SUM_W'(cur_head) + mcsq_pkg::SUM_W'(cur_count);
  assign tail_pos = (tail_sum >= mcsq_pkg::SUM_W'(mcsq_pkg::DEPTH))
                  ? mcsq_pkg::POS_W'(tail_sum - mcsq_pkg::SUM_W'(mcsq_pkg::DEPTH))
                  : mcsq_pkg::POS_W'(tail_sum);
  assign head_dec = (cur_head == '0) ? mcsq_pkg::POS_W'(mcsq_pkg::DEPTH - 1)
                                     : cur_head - mcsq_pkg::POS_W'(1);
  assign head_inc = (cur_head == mcsq_pkg::POS_W'(mcsq_pkg::DEPTH - 1))
                  ? '0 : cur_head + mcsq_pkg::POS_W'(1);

  // Command evaluation
  always_comb begin
    ex_status = mcsq_pkg::ST_OK;
    do_create = 1'b0;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    case (cmd_q.operation)
      mcsq_pkg::OP_CREATE: begin
        if (!in_range) begin
          ex_status = mcsq_pkg::ST_NO_LIST;
        end else if (cur_exists) begin
          ex_status = mcsq_pkg::ST_EXISTS;
        end else begin
          do_create = 1'b1;
        end
      end
      mcsq_pkg::OP_PUSH: begin
        if (!cur_exists) begin
          ex_status = mcsq_pkg::ST_NO_LIST;
        end else if (cur_count >= mcsq_pkg::CNT_W'(mcsq_pkg::DEPTH)) begin
          ex_status = mcsq_pkg::ST_FULL;
        end else begin
          do_push = 1'b1;
        end
      end
      mcsq_pkg::OP_POP: begin
        if (!cur_exists) begin
          ex_status = mcsq_pkg::ST_NO_LIST;
        end else if (cur_count == '0) begin
          ex_status = mcsq_pkg::ST_EMPTY;
        end else begin
          do_pop = 1'b1;
        end
      end
      default: begin
        ex_status = mcsq_pkg::ST_OK;
      end
    endcase
  end

  // Store slot and head update
  always_comb begin
    if (do_pop) begin
      slot_pos = cur_head;
      new_head = head_inc;
    end else if (cur_queue) begin
      slot_pos = tail_pos;
      new_head = cur_head;
    end else begin
      slot_pos = head_dec;
      new_head = head_dec;
    end
  end

  assign ram_addr = mcsq_pkg::ADDR_W'(32'(lst) * mcsq_pkg::DEPTH + 32'(slot_pos));
  assign ram_we   = (state == mcsq_pkg::S_EXEC) && do_push;
  assign ram_re   = (state == mcsq_pkg::S_EXEC) && do_pop;

  mcsq_ram #(
    .WIDTH (mcsq_pkg::VALUE_W),
    .DEPTH (mcsq_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (cmd_q.push_value),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mcsq_pkg::S_IDLE: begin
        if (start) begin
          state_next = mcsq_pkg::S_EXEC;
        end
      end
      mcsq_pkg::S_EXEC: begin
        state_next = do_pop ? mcsq_pkg::S_READ : mcsq_pkg::S_IDLE;
      end
      mcsq_pkg::S_READ: begin
        state_next = mcsq_pkg::S_IDLE;
      end
      default: begin
        state_next = mcsq_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs and result staging
  always_comb begin
    busy        = (state != mcsq_pkg::S_IDLE);
    done_next   = 1'b0;
    result_next = result;
    case (state)
      mcsq_pkg::S_EXEC: begin
        if (!do_pop) begin
          done_next                = 1'b1;
          result_next.status       = ex_status;
          result_next.pop_valid    = 1'b0;
          result_next.popped_value = '0;
        end
      end
      mcsq_pkg::S_READ: begin
        done_next                = 1'b1;
        result_next.status       = mcsq_pkg::ST_OK;
        result_next.pop_valid    = 1'b1;
        result_next.popped_value = ram_rdata;
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcsq_pkg::S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= command;
    end
    result <= result_next;
  end

  // Descriptor update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mcsq_pkg::NUM_LISTS; i++) begin
        list_exists[i] <= 1'b0;
      end
    end else if (state == mcsq_pkg::S_EXEC) begin
      if (do_create) begin
        list_exists[lst]   <= 1'b1;
        list_is_queue[lst] <= cmd_q.kind;
        head_index[lst]    <= '0;
        entry_count[lst]   <= '0;
      end else if (do_push) begin
        head_index[lst]  <= new_head;
        entry_count[lst] <= cur_count + mcsq_pkg::CNT_W'(1);
      end else if (do_pop) begin
        head_index[lst]  <= new_head;
        entry_count[lst] <= cur_count - mcsq_pkg::CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/mcsq_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the command and result channels
module mcsq_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire mcsq_pkg::result_t result
);

  // A transfer always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after command transfer");

  // A result only follows work in progress, and ends it
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result strobe without a command in progress");

  // Results never come in consecutive cycles
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // A popped value only comes with ok status
  a_pop_ok: assert property (@(posedge clk) disable iff (rst)
    (done && result.pop_valid) |-> (result.status == mcsq_pkg::ST_OK))
    else $error("popped value with error status");

  // No popped value means a zero value field
  a_no_pop_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.pop_valid) |-> (result.popped_value == '0))
    else $error("nonzero value on a result without a pop");

endmodule

bind multi_context_stack_queue mcsq_checker u_mcsq_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .result  (result)
);

`default_nettype wire

[sim/tb_multi_context_stack_queue.sv]
`timescale 1ns / 1ps

module tb_multi_context_stack_queue;
  import mcsq_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int CALM_TAIL    = 150;
  localparam logic [VALUE_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    cmd_t    cmd;
    bit      typed;
    result_t res;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    command = '0;
  logic    busy;
  logic    done;
  result_t result;

  multi_context_stack_queue dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .command (command),
    .done    (done),
    .result  (result)
  );

  always #2 clk = ~clk;

  // Shadow copy of the list descriptors and the value store
  bit                 list_live [NUM_LISTS];
  bit                 list_fifo [NUM_LISTS];
  int unsigned        list_head [NUM_LISTS];
  int unsigned        list_fill [NUM_LISTS];
  logic [VALUE_W-1:0] list_store [STORE_DEPTH];

  result_t pending_results[$];
  int      mismatch_count = 0;
  int      commands_sent  = 0;
  bit      idle_on        = 1'b1;

  // Hand-written expectation for the command currently presented
  bit      fixed_valid = 1'b0;
  result_t fixed_result = '0;

  // Apply one command to the shadow lists and return its result
  function automatic result_t apply_list_command(cmd_t c);
    result_t     r;
    int unsigned id;
    int unsigned pos;
    r = '0;
    r.status = ST_OK;
    id = 32'(c.list_id);
    if (c.operation == OP_NONE) begin
      r.status = ST_OK;
    end else if (id >= NUM_LISTS) begin
      r.status = ST_NO_LIST;
    end else if (c.operation == OP_CREATE) begin
      if (list_live[id]) begin
        r.status = ST_EXISTS;
      end else begin
        list_live[id] = 1'b1;
        list_fifo[id] = c.kind;
        list_head[id] = 0;
        list_fill[id] = 0;
      end
    end else if (!list_live[id]) begin
      r.status = ST_NO_LIST;
    end else if (c.operation == OP_PUSH) begin
      if (list_fill[id] >= DEPTH) begin
        r.status = ST_FULL;
      end else if (list_fifo[id]) begin
        // queue: write at the tail
        pos = (list_head[id] + list_fill[id]) % DEPTH;
        list_store[id * DEPTH + pos] = c.push_value;
        list_fill[id]++;
      end else begin
        // stack: move the head back, then write there
        pos = (list_head[id] + DEPTH - 1) % DEPTH;
        list_head[id] = pos;
        list_store[id * DEPTH + pos] = c.push_value;
        list_fill[id]++;
      end
    end else begin
      if (list_fill[id] == 0) begin
        r.status = ST_EMPTY;
      end else begin
        pos = list_head[id];
        r.pop_valid = 1'b1;
        r.popped_value = list_store[id * DEPTH + pos];
        list_head[id] = (pos + 1) % DEPTH;
        list_fill[id]--;
      end
    end
    return r;
  endfunction

  // Result check and command capture, both at the rising edge
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            mismatch_count++;
          end
          if (result.pop_valid !== want.pop_valid) begin
            $error("pop_valid: expected %0d, got %0d", want.pop_valid, result.pop_valid);
            mismatch_count++;
          end
          if (result.popped_value !== want.popped_value) begin
            $error("popped_value: expected %h, got %h", want.popped_value,
                   result.popped_value);
            mismatch_count++;
          end
        end
      end
      if (start && !busy) begin
        want = apply_list_command(command);
        pending_results.push_back(fixed_valid ? fixed_result : want);
      end
    end
  end

  function automatic cmd_t make_cmd(logic [1:0] op, int unsigned id, bit kind,
                                    logic [VALUE_W-1:0] v);
    cmd_t c;
    c.operation  = op;
    c.list_id    = LIST_ID_W'(id);
    c.kind       = kind;
    c.push_value = v;
    return c;
  endfunction

  function automatic result_t make_res(logic [2:0] st, bit pv, logic [VALUE_W-1:0] v);
    result_t r;
    r.status       = st;
    r.pop_valid    = pv;
    r.popped_value = v;
    return r;
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 15))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    int unsigned pick;
    logic [1:0]  op;
    pick = $urandom_range(0, 99);
    if (pick < 10)      op = OP_CREATE;
    else if (pick < 55) op = OP_PUSH;
    else if (pick < 95) op = OP_POP;
    else                op = OP_NONE;
    return make_cmd(op, $urandom_range(0, NUM_LISTS - 1), 1'($urandom_range(0, 1)),
                    rand_value());
  endfunction

  // Present one command at the falling edge and hold it until it transfers
  task automatic issue(input cmd_t c, input bit typed, input result_t exp_r);
    fixed_valid  = typed;
    fixed_result = exp_r;
    start   <= 1'b1;
    command <= c;
    do @(posedge clk); while (busy);
    if (c.operation != OP_NONE) commands_sent++;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    stim_row_t   rows[$];
    int unsigned rand_goal;
    int unsigned run_idx;
    int unsigned run_kind;
    int unsigned run_len;
    int unsigned id;

    // Directed table: expectation typed in for errors and extremes only
    rows.push_back('{make_cmd(OP_POP, 3, 1, 64'h55), 1, make_res(ST_NO_LIST, 0, '0)});
    rows.push_back('{make_cmd(OP_PUSH, 3, 0, 64'h5), 1, make_res(ST_NO_LIST, 0, '0)});
    rows.push_back('{make_cmd(OP_CREATE, 3, 0, '1), 1, make_res(ST_OK, 0, '0)});
    rows.push_back('{make_cmd(OP_CREATE, 3, 1, '0), 1, make_res(ST_EXISTS, 0, '0)});
    rows.push_back('{make_cmd(OP_POP, 3, 1, VAL_MAX), 1, make_res(ST_EMPTY, 0, '0)});
    rows.push_back('{make_cmd(OP_PUSH, 3, 1, VAL_MIN), 1, make_res(ST_OK, 0, '0)});
    rows.push_back('{make_cmd(OP_PUSH, 3, 0, VAL_MAX), 1, make_res(ST_OK, 0, '0)});
    rows.push_back('{make_cmd(OP_PUSH, 3, 0, 64'h1234_5678_9ABC_DEF0), 0, '0});
    rows.push_back('{make_cmd(OP_POP, 3, 0, '0), 0, '0});
    rows.push_back('{make_cmd(OP_POP, 3, 0, '0), 1, make_res(ST_OK, 1, VAL_MAX)});
    rows.push_back('{make_cmd(OP_POP, 3, 1, '1), 1, make_res(ST_OK, 1, VAL_MIN)});
    rows.push_back('{make_cmd(OP_POP, 3, 0, '0), 1, make_res(ST_EMPTY, 0, '0)});
    rows.push_back('{make_cmd(OP_CREATE, 0, 1, '0), 1, make_res(ST_OK, 0, '0)});
    rows.push_back('{make_cmd(OP_CREATE, 15, 0, VAL_MIN), 1, make_res(ST_OK, 0, '0)});
    rows.push_back('{make_cmd(OP_PUSH, 0, 0, VAL_MAX), 1, make_res(ST_OK, 0, '0)});
    rows.push_back('{make_cmd(OP_PUSH, 0, 1, VAL_MIN), 1, make_res(ST_OK, 0, '0)});
    rows.push_back('{make_cmd(OP_PUSH, 15, 1, '1), 0, '0});
    rows.push_back('{make_cmd(OP_POP, 0, 0, '0), 1, make_res(ST_OK, 1, VAL_MAX)});
    rows.push_back('{make_cmd(OP_POP, 0, 1, '0), 1, make_res(ST_OK, 1, VAL_MIN)});
    rows.push_back('{make_cmd(OP_POP, 15, 0, '0), 0, '0});
    rows.push_back('{make_cmd(OP_NONE, 7, 1, '1), 1, make_res(ST_OK, 0, '0)});
    rows.push_back('{make_cmd(OP_NONE, 0, 0, '0), 0, '0});
    rows.push_back('{make_cmd(OP_POP, 0, 1, '1), 1, make_res(ST_EMPTY, 0, '0)});

    // Hold reset, then release it at a falling edge
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) issue(rows[i].cmd, rows[i].typed, rows[i].res);

    // Let everything settle before the random traffic
    wait_all_results();

    // Random traffic in runs: fill runs push up to DEPTH + 6 values, drain runs
    // pop from a list, mixed runs cover everything else; the first two fill a queue
    // and a stack to the full limit
    rand_goal = commands_sent + RANDOM_ITEMS;
    run_idx = 0;
    while (commands_sent < rand_goal) begin
      if (commands_sent + CALM_TAIL >= rand_goal) idle_on = 1'b0;
      if (run_idx < 2) begin
        run_kind = 0;
        id       = (run_idx == 0) ? 0 : 3;
        run_len  = DEPTH + 6;
      end else begin
        run_kind = $urandom_range(0, 3);
        id       = $urandom_range(0, NUM_LISTS - 1);
        run_len  = $urandom_range(20, DEPTH + 6);
      end
      case (run_kind)
        0: begin
          issue(make_cmd(OP_CREATE, id, 1'($urandom_range(0, 1)), rand_value()), 1'b0, '0);
          repeat (run_len)
            issue(make_cmd(OP_PUSH, id, 1'($urandom_range(0, 1)), rand_value()), 1'b0, '0);
        end
        1: begin
          issue(make_cmd(OP_CREATE, id, 1'($urandom_range(0, 1)), rand_value()), 1'b0, '0);
          repeat (run_len)
            issue(make_cmd(OP_POP, id, 1'($urandom_range(0, 1)), rand_value()), 1'b0, '0);
        end
        default: begin
          repeat (run_len) issue(rand_cmd(), 1'b0, '0);
        end
      endcase
      if (idle_on && $urandom_range(0, 7) == 0) wait_all_results();
      run_idx++;
    end

    // Drain and allow for stray transfers
    wait_all_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
